// ===== rtl/sorted_unique_insert_list_defines.svh =====
// Assertion macros for the sorted unique insert list.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SORTED_UNIQUE_INSERT_LIST_DEFINES_SVH
`define SORTED_UNIQUE_INSERT_LIST_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define SUI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset
`define SUI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sui_pkg.sv =====
// Shared sizes, types and helpers for the sorted unique insert list.
// No dependencies; used by sui_store and sorted_unique_insert_list.
package sui_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int LINE_BITS   = 20;
  localparam int FIELD_W     = 5;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef logic [LINE_BITS-1:0]     line_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [FIELD_W-1:0]       field_t;
  typedef logic [CNT_W+FIELD_W-1:0] wide_t;

  // One port request to the entry store
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    line_t wr_data;
  } mem_req_t;

  // Compare of the last read entry against the key
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

  localparam cnt_t CNT_MAX = cnt_t'(MAX_ENTRIES);

  // Fit a count or position into the 5-bit result field
  function automatic field_t fit_field(input cnt_t v);
    wide_t w;
    w = wide_t'(v);
    return w[FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/sorted_unique_insert_list.sv =====
// Sorted unique insert list: ascending list of distinct line numbers, one result per word.
// Steps per word: accept, scan, then shift and write when inserting, and finish; one
// entry read and compared per scan cycle, one entry moved per shift cycle. Next word taken in the
// cycle after the result loads; a stalled result holds it.
// Reset (async, active low) clears the count, sequencer and output valid; the entry store
// has no reset and no clearing pass, entries at or above the count are never used.
`include "sorted_unique_insert_list_defines.svh"
module sorted_unique_insert_list (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sui_pkg::line_t  line_number_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            already_present_o,
  output logic            was_inserted_o,
  output logic            list_full_o,
  output sui_pkg::field_t slot_index_o,
  output sui_pkg::field_t entry_count_o
);
  import sui_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_FINISH
  } state_e;

  state_e   state_q;
  line_t    num_q;
  cnt_t     pos_q;
  cnt_t     cnt_q;
  idx_t     sh_q;
  logic     found_q, full_q, ins_q;
  logic     out_valid_q;
  logic     already_q, inserted_q, lfull_q;
  field_t   slot_q, count_q;

  mem_req_t mem_req;
  line_t    rd_data;
  cmp_t     cmp;
  cnt_t     pos_inc;
  idx_t     sh_prev;
  logic     in_acc;
  logic     out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pos_inc    = cnt_t'(pos_q + cnt_t'(1));
  assign sh_prev    = idx_t'(sh_q - idx_t'(1));

  sui_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .key_i     (num_q),
    .rd_data_o (rd_data),
    .cmp_o     (cmp)
  );

  // Store port control per sequencer step
  always_comb begin
    mem_req = '0;
    unique case (state_q)
      S_IDLE: begin
        // first entry read on accept
        mem_req.rd_en   = in_acc;
        mem_req.rd_addr = '0;
      end
      S_SCAN: begin
        if (!cmp.eq && !cmp.gt && (pos_inc != cnt_q)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_t'(pos_inc);
        end else if (!cmp.eq && cmp.gt && (cnt_q != CNT_MAX)) begin
          // top entry starts the shift
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_t'(cnt_q - cnt_t'(1));
        end
      end
      S_SHIFT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = sh_q;
        mem_req.wr_data = rd_data;
        if (cnt_t'(sh_prev) != pos_q) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_t'(sh_prev - idx_t'(1));
        end
      end
      S_WRITE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_t'(pos_q);
        mem_req.wr_data = num_q;
      end
      S_FINISH: begin
        mem_req = '0;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Sequencer, count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      sh_q        <= '0;
      found_q     <= 1'b0;
      full_q      <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
      already_q   <= 1'b0;
      inserted_q  <= 1'b0;
      lfull_q     <= 1'b0;
      slot_q      <= '0;
      count_q     <= '0;
    end else begin
      // taken result drops valid unless the finish step reloads it
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            num_q   <= line_number_i;
            pos_q   <= '0;
            found_q <= 1'b0;
            full_q  <= 1'b0;
            ins_q   <= 1'b0;
            state_q <= (cnt_q == '0) ? S_WRITE : S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (cmp.eq) begin
            found_q <= 1'b1;
            state_q <= S_FINISH;
          end else if (cmp.gt) begin
            if (cnt_q == CNT_MAX) begin
              full_q  <= 1'b1;
              state_q <= S_FINISH;
            end else begin
              sh_q    <= idx_t'(cnt_q);
              state_q <= S_SHIFT;
            end
          end else begin
            pos_q <= pos_inc;
            if (pos_inc == cnt_q) begin
              // larger than every entry: append or drop
              if (cnt_q == CNT_MAX) begin
                full_q  <= 1'b1;
                state_q <= S_FINISH;
              end else begin
                state_q <= S_WRITE;
              end
            end
          end
        end
        S_SHIFT: begin
          if (cnt_t'(sh_prev) == pos_q) begin
            state_q <= S_WRITE;
          end else begin
            sh_q <= sh_prev;
          end
        end
        S_WRITE: begin
          cnt_q   <= cnt_t'(cnt_q + cnt_t'(1));
          ins_q   <= 1'b1;
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            already_q   <= found_q;
            inserted_q  <= ins_q;
            lfull_q     <= full_q;
            slot_q      <= fit_field(pos_q);
            count_q     <= fit_field(cnt_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign already_present_o = already_q;
  assign was_inserted_o    = inserted_q;
  assign list_full_o       = lfull_q;
  assign slot_index_o      = slot_q;
  assign entry_count_o     = count_q;

  // Checks
  `SUI_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "accepted word did not start work")
  `SUI_ASSERT_NEXT(a_write_bumps_count, state_q == S_WRITE,
                   cnt_q == cnt_t'($past(cnt_q) + cnt_t'(1)), "insert did not bump count")
  `SUI_ASSERT_NOW(a_full_count, out_valid_o && list_full_o,
                  entry_count_o == fit_field(CNT_MAX), "dropped word with list not full")
  `SUI_ASSERT_NOW(a_count_bound, state_q == S_IDLE, cnt_q <= CNT_MAX, "count past capacity")

endmodule

// ===== rtl/sui_store.sv =====
// Entry store with one registered read port, one write port and the compare unit.
// Depends on sui_pkg.
module sui_store (
  input  logic               clk_i,
  input  sui_pkg::mem_req_t  req_i,
  input  sui_pkg::line_t     key_i,
  output sui_pkg::line_t     rd_data_o,
  output sui_pkg::cmp_t      cmp_o
);
  import sui_pkg::*;

  line_t mem [MAX_ENTRIES];
  line_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // Shared comparator on the read word
  assign cmp_o.eq  = (rd_data_q == key_i);
  assign cmp_o.gt  = (rd_data_q > key_i);
  assign rd_data_o = rd_data_q;

endmodule
